/* hdl/upts_pkg.sv */
// Shared types, constants and the toned-vowel lookup for the pinyin tone stripper.
`default_nettype none

package upts_pkg;

  // Command queue between front and back; depth is a power of two.
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);

  localparam int unsigned ToneCount = 24;

  // One unit of work for the back end: one or two bytes to send.
  typedef struct packed {
    logic       two;
    logic [7:0] first;
    logic [7:0] second;
    logic       fin;
  } cmd_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] letter;
  } tone_hit_t;

  localparam logic [15:0] TonePair [ToneCount] = '{
    16'hC481, 16'hC3A1, 16'hC78E, 16'hC3A0,
    16'hC493, 16'hC3A9, 16'hC49B, 16'hC3A8,
    16'hC4AB, 16'hC3AD, 16'hC790, 16'hC3AC,
    16'hC58D, 16'hC3B3, 16'hC792, 16'hC3B2,
    16'hC5AB, 16'hC3BA, 16'hC794, 16'hC3B9,
    16'hC796, 16'hC798, 16'hC79A, 16'hC79C
  };

  localparam logic [7:0] ToneBase [ToneCount] = '{
    8'h61, 8'h61, 8'h61, 8'h61, 8'h65, 8'h65, 8'h65, 8'h65,
    8'h69, 8'h69, 8'h69, 8'h69, 8'h6F, 8'h6F, 8'h6F, 8'h6F,
    8'h75, 8'h75, 8'h75, 8'h75, 8'h76, 8'h76, 8'h76, 8'h76
  };

  // Independent compares against the 24 lead/second pairs.
  function automatic tone_hit_t tone_lookup(input logic [7:0] lead, input logic [7:0] second);
    tone_hit_t res;
    res.hit    = 1'b0;
    res.letter = 8'h00;
    for (int k = 0; k < ToneCount; k++) begin
      if (TonePair[k] == {lead, second}) begin
        res.hit    = 1'b1;
        res.letter = ToneBase[k];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* hdl/upts_front.sv */
// Front end: tracks character alignment; input beats become commands, two-byte leads are held.
`default_nettype none

module upts_front import upts_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_end_i,
  output cmd_t            cmd_o,
  output logic            cmd_push_o
);

  typedef enum logic [1:0] {
    LkSingle,
    LkTwo,
    LkThree,
    LkFour
  } lead_kind_e;

  function automatic lead_kind_e classify(input logic [7:0] b);
    lead_kind_e k;
    if (b[7] == 1'b0) k = LkSingle;
    else if ((b & 8'hE0) == 8'hC0) k = LkTwo;
    else if ((b & 8'hF0) == 8'hE0) k = LkThree;
    else if ((b & 8'hF8) == 8'hF0) k = LkFour;
    else k = LkSingle;  // stray continuation or invalid lead
    return k;
  endfunction

  logic [7:0] held_lead_q, held_lead_d;
  logic       held_valid_q, held_valid_d;
  logic [1:0] pass_q, pass_d;
  tone_hit_t  hit;
  lead_kind_e kind;

  always_comb begin
    hit          = tone_lookup(held_lead_q, in_byte_i);
    kind         = classify(in_byte_i);
    held_lead_d  = held_lead_q;
    held_valid_d = held_valid_q;
    pass_d       = pass_q;
    cmd_push_o   = 1'b0;
    cmd_o.two    = 1'b0;
    cmd_o.first  = in_byte_i;
    cmd_o.second = in_byte_i;
    cmd_o.fin    = in_end_i;
    if (accept_i) begin
      cmd_push_o = 1'b1;
      if (held_valid_q) begin
        if (hit.hit) begin
          cmd_o.first = hit.letter;
        end else begin
          cmd_o.two   = 1'b1;
          cmd_o.first = held_lead_q;
        end
        held_valid_d = 1'b0;
        held_lead_d  = 8'h00;
      end else if (pass_q != 2'd0) begin
        pass_d = pass_q - 2'd1;
      end else begin
        case (kind)
          LkTwo: begin
            if (!in_end_i) begin
              cmd_push_o   = 1'b0;
              held_lead_d  = in_byte_i;
              held_valid_d = 1'b1;
            end
          end
          LkThree: pass_d = 2'd2;
          LkFour:  pass_d = 2'd3;
          default: pass_d = 2'd0;
        endcase
      end
      if (in_end_i) begin
        held_valid_d = 1'b0;
        held_lead_d  = 8'h00;
        pass_d       = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_lead_q  <= 8'h00;
      held_valid_q <= 1'b0;
      pass_q       <= 2'd0;
    end else begin
      held_lead_q  <= held_lead_d;
      held_valid_q <= held_valid_d;
      pass_q       <= pass_d;
    end
  end

`ifndef SYNTHESIS
  a_hold_excl_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(held_valid_q && (pass_q != 2'd0)))
    else $error("lead held while continuation bytes still pass");
`endif

endmodule

`default_nettype wire

/* hdl/upts_cmd_fifo.sv */
// Short command queue between front and back.
`default_nettype none

module upts_cmd_fifo import upts_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output cmd_t      cmd_o,
  output logic      valid_o,
  output logic      full_o
);

  cmd_t               mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CmdPtrW:0]   count_q;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == (CmdPtrW+1)'(CmdDepth));
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("command queue popped while empty");
`endif

endmodule

`default_nettype wire

/* hdl/upts_back.sv */
// Back end: expands commands into output beats held in an output register.
`default_nettype none

module upts_back import upts_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cmd_t       cmd_i,
  input  wire logic       cmd_valid_i,
  output logic            cmd_pop_o,
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            string_last_o
);

  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q, byte_d;
  logic       run_last_q, run_last_d;
  logic       str_last_q, str_last_d;
  logic       phase_q, phase_d;  // high while the second byte of a pair is due
  logic       load;

  assign load = cmd_valid_i && (!out_valid_q || pop);

  always_comb begin
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    run_last_d  = run_last_q;
    str_last_d  = str_last_q;
    phase_d     = phase_q;
    cmd_pop_o   = 1'b0;
    if (load) begin
      out_valid_d = 1'b1;
      if (phase_q) begin
        byte_d     = cmd_i.second;
        run_last_d = 1'b1;
        str_last_d = cmd_i.fin;
        phase_d    = 1'b0;
        cmd_pop_o  = 1'b1;
      end else begin
        byte_d     = cmd_i.first;
        run_last_d = !cmd_i.two;
        str_last_d = !cmd_i.two && cmd_i.fin;
        phase_d    = cmd_i.two;
        cmd_pop_o  = !cmd_i.two;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    run_last_q <= run_last_d;
    str_last_q <= str_last_d;
  end

  assign empty         = !out_valid_q;
  assign out_byte_o    = byte_q;
  assign run_last_o    = run_last_q;
  assign string_last_o = str_last_q;

`ifndef SYNTHESIS
  a_pair_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> cmd_valid_i)
    else $error("second byte due but its command left the queue");
`endif

endmodule

`default_nettype wire

/* hdl/utf8_pinyin_tone_strip.sv */
// Top level of the UTF-8 pinyin tone stripper.
//
//   channel | handshake        | payload
//   --------+------------------+----------------------------------------
//   input   | push / full      | in_byte_i, in_end_i
//   result  | empty / pop      | out_byte_o, run_last_o, string_last_o
//
// One input beat per cycle while full is low; each beat yields zero, one or
// two result beats. The result side drains one beat per cycle while pop is
// high, so a mismatched pair's extra result beat is absorbed by the two-entry
// command queue. An accepted beat passes through the command queue and then
// the output register, from which its result is popped. Reset clears
// alignment state, the queue and the output valid flag, not the output data.
// Either side may stall on its own; full rises only when the queue fills.
`default_nettype none

module utf8_pinyin_tone_strip import upts_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_end_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            string_last_o
);

  cmd_t front_cmd, head_cmd;
  logic front_push, head_valid, head_pop, accept;

  assign accept = push && !full;

  upts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .in_end_i   (in_end_i),
    .cmd_o      (front_cmd),
    .cmd_push_o (front_push)
  );

  upts_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .cmd_i   (front_cmd),
    .pop_i   (head_pop),
    .cmd_o   (head_cmd),
    .valid_o (head_valid),
    .full_o  (full)
  );

  upts_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (head_cmd),
    .cmd_valid_i   (head_valid),
    .cmd_pop_o     (head_pop),
    .pop           (pop),
    .empty         (empty),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .string_last_o (string_last_o)
  );

endmodule

`default_nettype wire
